@@ hw/rtl/power_monitor_status_parser_macros.svh @@
// Assertion macros shared by the status parser RTL.
`ifndef POWER_MONITOR_STATUS_PARSER_MACROS_SVH
`define POWER_MONITOR_STATUS_PARSER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PMSP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define PMSP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/pmsp_pkg.sv @@
// Types, character codes and helpers for the status parser.
package pmsp_pkg;

    localparam int unsigned IN_DATA_W  = 8;
    localparam int unsigned VALUE_W    = 32;
    localparam int unsigned NUM_FLAGS  = 5;
    localparam int unsigned OUT_DATA_W = 168;   // 5 x 32 + 5, padded to bytes
    localparam int unsigned KIND_W     = 3;
    localparam int unsigned FLAG_NAME_LEN = 4;

    typedef enum logic [KIND_W-1:0] {
        KIND_NONE  = 3'd0,
        KIND_VOLT  = 3'd1,
        KIND_AMP   = 3'd2,
        KIND_REF   = 3'd3,
        KIND_FLAG  = 3'd4
    } t_kind;

    localparam logic [7:0] CHR_0      = 8'h30;
    localparam logic [7:0] CHR_9      = 8'h39;
    localparam logic [7:0] CHR_UP_A   = 8'h41;
    localparam logic [7:0] CHR_UP_Z   = 8'h5A;
    localparam logic [7:0] CHR_LO_A   = 8'h61;
    localparam logic [7:0] CHR_LO_Z   = 8'h7A;
    localparam logic [7:0] CHR_CASE   = 8'h20;
    localparam logic [7:0] CHR_M      = 8'h6D;
    localparam logic [7:0] CHR_V      = 8'h76;
    localparam logic [7:0] CHR_AMP    = 8'h61;
    localparam logic [7:0] CHR_O      = 8'h6F;
    localparam logic [7:0] CHR_N      = 8'h6E;
    localparam logic [7:0] CHR_F      = 8'h66;
    localparam logic [7:0] CHR_SLASH  = 8'h2F;
    localparam logic [7:0] CHR_COLON  = 8'h3A;
    localparam logic [7:0] CHR_EQUAL  = 8'h3D;

    // first character in the top byte
    localparam logic [31:0] FLAG_NAME [NUM_FLAGS] = '{
        "vbat", "btn1", "btn2", "btn3", "vbus"
    };

    // acc * 10 + digit, modulo 2^32; the digit is the low nibble of an ASCII digit
    function automatic logic [VALUE_W-1:0] dec_step(
        input logic [VALUE_W-1:0] acc,
        input logic [7:0]         chr
    );
        logic [VALUE_W-1:0] x8;
        logic [VALUE_W-1:0] x2;
        x8 = {acc[VALUE_W-4:0], 3'b000};
        x2 = {acc[VALUE_W-2:0], 1'b0};
        return x8 + x2 + {{(VALUE_W-4){1'b0}}, chr[3:0]};
    endfunction

endpackage

@@ hw/rtl/power_monitor_status_parser.sv @@
// Status text parser for a bench power controller: one byte in, one status word out.
//
//  channel | dir | handshake                     | word
//  --------+-----+-------------------------------+------------------------------------
//  s_axis  | in  | s_axis_tvalid / s_axis_tready | tdata: status_byte
//  m_axis  | out | m_axis_tvalid / m_axis_tready | tuser: update_kind, tdata: readings
//
//  Path: input reg, then parse into out reg; the parse step is one compare tree and one x10 add.
//  Throughput: one byte per cycle while m_axis is not stalled.
//  Parser state and readings advance only when a byte moves from the input reg to the out reg,
//  so the output readings are the live state registers and hold while the output stalls.
//  The input reg acts as a skid stage: a byte is taken while a result waits to be read.
//  Reset (i_rst_n low, synchronous) empties both stages, sets the parser idle and clears readings.
`include "power_monitor_status_parser_macros.svh"

module power_monitor_status_parser
    import pmsp_pkg::*;
#(
    parameter int unsigned KEY_LEN = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [7:0] status_byte

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [31:0] voltage_setpoint_mv, [63:32] voltage_measured_mv,
    // [95:64] current_setpoint_ma, [127:96] current_measured_ma,
    // [159:128] reference_mv, [164:160] flag_bits, [167:165] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic [KIND_W-1:0]     m_axis_tuser    // [2:0] update_kind
);

    // key length never exceeds KEY_LEN-1, so clog2 bits are enough
    localparam int unsigned KL_W = $clog2(KEY_LEN);

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_KEY       = 4'd1,
        PH_KEY_BOOL  = 4'd2,
        PH_KEY_VALUE = 4'd3,
        PH_KEY_O     = 4'd4,
        PH_KEY_OF    = 4'd5,
        PH_KEY_NUM   = 4'd6,
        PH_KEY_NUM_M = 4'd7,
        PH_NUM       = 4'd8,
        PH_NUM_M     = 4'd9,
        PH_NUM_MX    = 4'd10,
        PH_NUM_MX_S  = 4'd11,
        PH_NUM_NUM_M = 4'd12
    } t_phase;

    // handshake / stage control
    logic                 r_in_valid;
    logic [7:0]           r_in_byte;
    logic                 r_out_valid;
    t_kind                r_kind;
    logic                 advance;
    logic                 process;

    // parser state
    t_phase               r_phase,   n_phase;
    logic [VALUE_W-1:0]   r_first,   n_first;
    logic [VALUE_W-1:0]   r_second,  n_second;
    logic [7:0]           r_key_chr [FLAG_NAME_LEN];
    logic [7:0]           n_key_chr [FLAG_NAME_LEN];
    logic [KL_W-1:0]      r_key_len, n_key_len;
    logic                 r_unit_v,  n_unit_v;
    t_kind                n_kind;

    // readings
    logic [VALUE_W-1:0]   r_vset,  n_vset;
    logic [VALUE_W-1:0]   r_vmeas, n_vmeas;
    logic [VALUE_W-1:0]   r_aset,  n_aset;
    logic [VALUE_W-1:0]   r_ameas, n_ameas;
    logic [VALUE_W-1:0]   r_ref,   n_ref;
    logic [NUM_FLAGS-1:0] r_flags, n_flags;

    logic [7:0]           chr;
    logic                 is_dig;
    logic                 is_alp;
    logic [31:0]          key_word;
    logic [NUM_FLAGS-1:0] flag_hit;

    // out reg frees up when empty or being read; input reg moves on then
    assign advance       = !r_out_valid || m_axis_tready;
    assign process       = r_in_valid && advance;
    assign s_axis_tready = !r_in_valid || advance;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_kind;
    assign m_axis_tdata  = {3'b000, r_flags, r_ref, r_ameas, r_aset, r_vmeas, r_vset};

    // fold to lower case, classify
    always_comb begin
        chr = r_in_byte;
        if (r_in_byte >= CHR_UP_A && r_in_byte <= CHR_UP_Z) begin
            chr = r_in_byte + CHR_CASE;
        end
        is_dig = (chr >= CHR_0) && (chr <= CHR_9);
        is_alp = (chr >= CHR_LO_A) && (chr <= CHR_LO_Z);
    end

    // only the first four key characters matter: flag names are four long
    assign key_word = {r_key_chr[0], r_key_chr[1], r_key_chr[2], r_key_chr[3]};

    always_comb begin
        for (int i = 0; i < NUM_FLAGS; i++) begin
            flag_hit[i] = (r_key_len == KL_W'(FLAG_NAME_LEN)) && (key_word == FLAG_NAME[i]);
        end
    end

    // one parse step
    always_comb begin
        n_phase   = PH_IDLE;      // unexpected byte: back to idle, byte dropped
        n_kind    = KIND_NONE;
        n_first   = r_first;
        n_second  = r_second;
        n_key_chr = r_key_chr;
        n_key_len = r_key_len;
        n_unit_v  = r_unit_v;
        n_vset    = r_vset;
        n_vmeas   = r_vmeas;
        n_aset    = r_aset;
        n_ameas   = r_ameas;
        n_ref     = r_ref;
        n_flags   = r_flags;

        case (r_phase)
            PH_IDLE: begin
                if (is_dig) begin
                    n_first = {{(VALUE_W-4){1'b0}}, chr[3:0]};
                    n_phase = PH_NUM;
                end else if (is_alp) begin
                    n_key_chr[0] = chr;
                    n_key_len    = KL_W'(1);
                    n_phase      = PH_KEY;
                end
            end
            PH_NUM: begin
                if (is_dig) begin
                    n_first = dec_step(r_first, chr);
                    n_phase = PH_NUM;
                end else if (chr == CHR_M) begin
                    n_phase = PH_NUM_M;
                end
            end
            PH_NUM_M: begin
                if (chr == CHR_V || chr == CHR_AMP) begin
                    n_unit_v = (chr == CHR_V);
                    n_phase  = PH_NUM_MX;
                end
            end
            PH_NUM_MX: begin
                if (chr == CHR_SLASH) begin
                    n_second = '0;
                    n_phase  = PH_NUM_MX_S;
                end
            end
            PH_NUM_MX_S: begin
                if (is_dig) begin
                    n_second = dec_step(r_second, chr);
                    n_phase  = PH_NUM_MX_S;
                end else if (chr == CHR_M) begin
                    n_phase = PH_NUM_NUM_M;
                end
            end
            PH_NUM_NUM_M: begin
                // unit mismatch drops the record
                if (chr == CHR_V && r_unit_v) begin
                    n_vset  = r_first;
                    n_vmeas = r_second;
                    n_kind  = KIND_VOLT;
                end else if (chr == CHR_AMP && !r_unit_v) begin
                    n_aset  = r_first;
                    n_ameas = r_second;
                    n_kind  = KIND_AMP;
                end
            end
            PH_KEY: begin
                if (is_dig || is_alp) begin
                    // key too long: fall back to idle
                    if (r_key_len < KL_W'(KEY_LEN - 1)) begin
                        if (r_key_len < KL_W'(FLAG_NAME_LEN)) begin
                            n_key_chr[r_key_len[1:0]] = chr;
                        end
                        n_key_len = r_key_len + KL_W'(1);
                        n_phase   = PH_KEY;
                    end
                end else if (chr == CHR_COLON) begin
                    n_phase = PH_KEY_BOOL;
                end else if (chr == CHR_EQUAL) begin
                    n_phase = PH_KEY_VALUE;
                end
            end
            PH_KEY_BOOL: begin
                if (chr == CHR_O) begin
                    n_phase = PH_KEY_O;
                end
            end
            PH_KEY_O: begin
                if (chr == CHR_F) begin
                    n_phase = PH_KEY_OF;
                end else if (chr == CHR_N && (|flag_hit)) begin
                    n_flags = r_flags | flag_hit;
                    n_kind  = KIND_FLAG;
                end
            end
            PH_KEY_OF: begin
                if (chr == CHR_F && (|flag_hit)) begin
                    n_flags = r_flags & ~flag_hit;
                    n_kind  = KIND_FLAG;
                end
            end
            PH_KEY_VALUE: begin
                if (is_dig) begin
                    n_first = {{(VALUE_W-4){1'b0}}, chr[3:0]};
                    n_phase = PH_KEY_NUM;
                end
            end
            PH_KEY_NUM: begin
                if (is_dig) begin
                    n_first = dec_step(r_first, chr);
                    n_phase = PH_KEY_NUM;
                end else if (chr == CHR_M) begin
                    n_phase = PH_KEY_NUM_M;
                end
            end
            PH_KEY_NUM_M: begin
                // any key name sets the reference
                if (chr == CHR_V) begin
                    n_ref  = r_first;
                    n_kind = KIND_REF;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
        end
    end

    // parse stage and output reg
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_kind      <= KIND_NONE;
            r_phase     <= PH_IDLE;
            r_first     <= '0;
            r_second    <= '0;
            r_key_len   <= '0;
            r_unit_v    <= 1'b0;
            r_vset      <= '0;
            r_vmeas     <= '0;
            r_aset      <= '0;
            r_ameas     <= '0;
            r_ref       <= '0;
            r_flags     <= '0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
            if (process) begin
                r_kind    <= n_kind;
                r_phase   <= n_phase;
                r_first   <= n_first;
                r_second  <= n_second;
                r_key_len <= n_key_len;
                r_unit_v  <= n_unit_v;
                r_vset    <= n_vset;
                r_vmeas   <= n_vmeas;
                r_aset    <= n_aset;
                r_ameas   <= n_ameas;
                r_ref     <= n_ref;
                r_flags   <= n_flags;
            end
        end
    end

    // key characters: no reset, only written entries are ever compared
    always_ff @(posedge i_clk) begin
        if (process) begin
            r_key_chr <= n_key_chr;
        end
    end

    // readings must not move under a stalled result
    `PMSP_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, r_out_valid && !m_axis_tready, $stable(m_axis_tdata) && $stable(r_phase), "readings changed under a stalled result")
    // a completed record always leaves the parser idle
    `PMSP_ASSERT_NOW(a_done_idle, i_clk, i_rst_n, r_out_valid && (r_kind != KIND_NONE), r_phase == PH_IDLE, "record reported but parser not idle")
    // a flag update needs a four-character key
    `PMSP_ASSERT_NOW(a_flag_key, i_clk, i_rst_n, r_out_valid && (r_kind == KIND_FLAG), r_key_len == KL_W'(FLAG_NAME_LEN), "flag update with wrong key length")
    // key counter stays inside its bound
    `PMSP_ASSERT_NOW(a_key_bound, i_clk, i_rst_n, 1'b1, r_key_len <= KL_W'(KEY_LEN - 1), "key length past bound")

endmodule
